[rtl/core/sts_pkg.sv]
// Shared types, keyword tables and character class functions of the token scanner.
`default_nettype none

package sts_pkg;

    localparam int MAX_TOKEN_LENGTH_DEF = 255;
    localparam int KW_COUNT             = 11;
    localparam int KW_SLOTS             = 8;
    localparam int FIFO_DEPTH           = 4;
    localparam int FIFO_PTR_W           = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W           = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [4:0] {
        TK_ERROR   = 5'd0,
        TK_EOF     = 5'd1,
        TK_DEFINE  = 5'd2,
        TK_SET     = 5'd3,
        TK_LAMBDA  = 5'd4,
        TK_IF      = 5'd5,
        TK_COND    = 5'd6,
        TK_BEGIN   = 5'd7,
        TK_OPEN    = 5'd8,
        TK_CLOSE   = 5'd9,
        TK_ADD     = 5'd10,
        TK_SUB     = 5'd11,
        TK_MUL     = 5'd12,
        TK_DIV     = 5'd13,
        TK_GT      = 5'd14,
        TK_LT      = 5'd15,
        TK_EQ      = 5'd16,
        TK_AND     = 5'd17,
        TK_OR      = 5'd18,
        TK_NOT     = 5'd19,
        TK_BOX     = 5'd20,
        TK_NIL     = 5'd21,
        TK_SYMBOL  = 5'd22,
        TK_INTEGER = 5'd23,
        TK_SPACE   = 5'd24,
        TK_NEWLINE = 5'd25
    } tok_kind_t;

    typedef enum logic [4:0] {
        MODE_IDLE  = 5'b00001,
        MODE_SPACE = 5'b00010,
        MODE_SIGN  = 5'b00100,
        MODE_INT   = 5'b01000,
        MODE_IDENT = 5'b10000
    } scan_mode_t;

    typedef struct packed {
        tok_kind_t   kind;
        logic [7:0]  length;
        logic        last;
    } token_t;

    typedef struct packed {
        logic [1:0]  count;
        token_t      tok0;
        token_t      tok1;
    } scan_out_t;

    // Keyword spellings, padded with zeros to eight slots.
    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_SLOTS] = '{
        '{"d", "e", "f", "i", "n", "e", 8'h00, 8'h00},
        '{"l", "a", "m", "b", "d", "a", 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", "o", "n", "d", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"b", "e", "g", "i", "n", 8'h00, 8'h00, 8'h00},
        '{"a", "n", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"n", "o", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"b", "o", "x", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"n", "i", "l", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"s", "e", "t", "!", 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd6, 3'd6, 3'd2, 3'd4, 3'd5, 3'd3, 3'd2, 3'd3, 3'd3, 3'd3, 3'd4
    };

    localparam tok_kind_t KW_KIND [KW_COUNT] = '{
        TK_DEFINE, TK_LAMBDA, TK_IF, TK_COND, TK_BEGIN, TK_AND,
        TK_OR, TK_NOT, TK_BOX, TK_NIL, TK_SET
    };

    localparam logic [7:0] CH_NUL     = 8'd0;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_OPEN    = 8'd40;
    localparam logic [7:0] CH_CLOSE   = 8'd41;
    localparam logic [7:0] CH_STAR    = 8'd42;
    localparam logic [7:0] CH_PLUS    = 8'd43;
    localparam logic [7:0] CH_MINUS   = 8'd45;
    localparam logic [7:0] CH_SLASH   = 8'd47;
    localparam logic [7:0] CH_LT      = 8'd60;
    localparam logic [7:0] CH_EQ      = 8'd61;
    localparam logic [7:0] CH_GT      = 8'd62;
    localparam logic [7:0] CH_BANG    = 8'd33;
    localparam logic [7:0] CH_QUERY   = 8'd63;

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {8'd9, 8'd11, 8'd12, 8'd13, 8'd32};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'd48:8'd57]};
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return c inside {[8'd65:8'd90], [8'd97:8'd122]};
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        return is_blank(c) || c == CH_NEWLINE || c == CH_CLOSE || c == CH_NUL;
    endfunction

    function automatic logic is_id_char(input logic [7:0] c);
        return is_letter(c) || is_digit(c) || c == CH_BANG || c == CH_MINUS
            || c == CH_QUERY;
    endfunction

endpackage

`default_nettype wire

[rtl/core/sts_scan_core.sv]
// Scanner state and the per-character token decision logic.
`default_nettype none

module sts_scan_core
    import sts_pkg::*;
#(
    parameter int MAX_TOKEN_LENGTH = MAX_TOKEN_LENGTH_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] ch,
    output scan_out_t       res
);

    localparam int LEN_W = $clog2(MAX_TOKEN_LENGTH + 1);
    localparam logic [LEN_W-1:0] MAX_LEN_C = LEN_W'(MAX_TOKEN_LENGTH);

    scan_mode_t            mode_reg, mode_next;
    logic [LEN_W-1:0]      run_reg, run_next;
    logic                  minus_reg, minus_next;
    logic [KW_COUNT-1:0]   cand_reg, cand_next;

    logic [LEN_W-1:0]      run_inc;
    logic                  hold;
    logic                  rescan;
    logic                  pend_emit;
    tok_kind_t             pend_kind;
    logic [LEN_W-1:0]      pend_len;
    logic                  idle_emit;
    tok_kind_t             idle_kind;
    logic [7:0]            idle_len;
    token_t                pend_tok, idle_tok;

    function automatic logic [KW_COUNT-1:0] kw_filter(input logic [KW_COUNT-1:0] cand,
                                                      input logic [7:0] c,
                                                      input logic [LEN_W-1:0] pos);
        logic [KW_COUNT-1:0] r;
        r = cand;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (pos >= LEN_W'(KW_LEN[i]) || KW_TEXT[i][pos[2:0]] != c) begin
                r[i] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic tok_kind_t ident_kind(input logic [KW_COUNT-1:0] cand,
                                             input logic [LEN_W-1:0] len);
        tok_kind_t k;
        logic      found;
        k     = TK_SYMBOL;
        found = 1'b0;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (!found && cand[i] && len == LEN_W'(KW_LEN[i])) begin
                k     = KW_KIND[i];
                found = 1'b1;
            end
        end
        return k;
    endfunction

    // Lengths above eight bits report as 255.
    function automatic logic [7:0] cap_len(input logic [LEN_W-1:0] v);
        logic [LEN_W+7:0] wide;
        wide = (LEN_W + 8)'(v);
        return (wide > (LEN_W + 8)'(255)) ? 8'hFF : wide[7:0];
    endfunction

    assign run_inc = (run_reg >= MAX_LEN_C) ? MAX_LEN_C : run_reg + LEN_W'(1);

    always_comb
    begin
        mode_next  = mode_reg;
        run_next   = run_reg;
        minus_next = minus_reg;
        cand_next  = cand_reg;
        hold       = 1'b0;
        rescan     = 1'b1;
        pend_emit  = 1'b0;
        pend_kind  = TK_ERROR;
        pend_len   = '0;
        idle_emit  = 1'b0;
        idle_kind  = TK_ERROR;
        idle_len   = 8'd1;

        case (mode_reg)
            MODE_SPACE:
            begin
                if (is_blank(ch)) begin
                    run_next = run_inc;
                    hold     = 1'b1;
                end else begin
                    pend_emit = 1'b1;
                    pend_kind = TK_SPACE;
                    pend_len  = run_reg;
                end
            end
            MODE_SIGN:
            begin
                if (is_digit(ch)) begin
                    mode_next = MODE_INT;
                    run_next  = run_inc;
                    hold      = 1'b1;
                end else if (is_delim(ch)) begin
                    pend_emit = 1'b1;
                    pend_kind = minus_reg ? TK_SUB : TK_ADD;
                    pend_len  = LEN_W'(1);
                end else begin
                    pend_emit = 1'b1;
                    pend_kind = TK_ERROR;
                    pend_len  = run_inc;
                    rescan    = 1'b0;
                end
            end
            MODE_INT:
            begin
                if (is_digit(ch)) begin
                    run_next = run_inc;
                    hold     = 1'b1;
                end else if (is_delim(ch)) begin
                    pend_emit = 1'b1;
                    pend_kind = TK_INTEGER;
                    pend_len  = run_reg;
                end else begin
                    pend_emit = 1'b1;
                    pend_kind = TK_ERROR;
                    pend_len  = run_inc;
                    rescan    = 1'b0;
                end
            end
            MODE_IDENT:
            begin
                if (is_id_char(ch)) begin
                    cand_next = kw_filter(cand_reg, ch, run_reg);
                    run_next  = run_inc;
                    hold      = 1'b1;
                end else begin
                    pend_emit = 1'b1;
                    pend_kind = ident_kind(cand_reg, run_reg);
                    pend_len  = run_reg;
                end
            end
            default:
            begin
            end
        endcase

        // The character that closed a pending token is scanned again from idle, unless an error token took it in.
        if (!hold) begin
            mode_next = MODE_IDLE;
            run_next  = '0;
            if (rescan) begin
                case (ch)
                    CH_NUL:
                    begin
                        idle_emit = 1'b1;
                        idle_kind = TK_EOF;
                        idle_len  = 8'd0;
                    end
                    CH_NEWLINE: begin idle_emit = 1'b1; idle_kind = TK_NEWLINE; end
                    CH_OPEN:    begin idle_emit = 1'b1; idle_kind = TK_OPEN;    end
                    CH_CLOSE:   begin idle_emit = 1'b1; idle_kind = TK_CLOSE;   end
                    CH_STAR:    begin idle_emit = 1'b1; idle_kind = TK_MUL;     end
                    CH_SLASH:   begin idle_emit = 1'b1; idle_kind = TK_DIV;     end
                    CH_GT:      begin idle_emit = 1'b1; idle_kind = TK_GT;      end
                    CH_LT:      begin idle_emit = 1'b1; idle_kind = TK_LT;      end
                    CH_EQ:      begin idle_emit = 1'b1; idle_kind = TK_EQ;      end
                    default:
                    begin
                        if (is_blank(ch)) begin
                            mode_next = MODE_SPACE;
                            run_next  = LEN_W'(1);
                        end else if (ch == CH_PLUS || ch == CH_MINUS) begin
                            mode_next  = MODE_SIGN;
                            run_next   = LEN_W'(1);
                            minus_next = (ch == CH_MINUS);
                        end else if (is_digit(ch)) begin
                            mode_next = MODE_INT;
                            run_next  = LEN_W'(1);
                        end else if (is_letter(ch)) begin
                            mode_next = MODE_IDENT;
                            run_next  = LEN_W'(1);
                            cand_next = kw_filter('1, ch, '0);
                        end else begin
                            idle_emit = 1'b1;
                            idle_kind = TK_ERROR;
                        end
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        pend_tok.kind   = pend_kind;
        pend_tok.length = cap_len(pend_len);
        pend_tok.last   = !idle_emit;
        idle_tok.kind   = idle_kind;
        idle_tok.length = idle_len;
        idle_tok.last   = 1'b1;
        res.count       = {1'b0, pend_emit} + {1'b0, idle_emit};
        res.tok0        = pend_emit ? pend_tok : idle_tok;
        res.tok1        = idle_tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= MODE_IDLE;
            run_reg   <= '0;
            minus_reg <= 1'b0;
            cand_reg  <= '1;
        end else if (step) begin
            mode_reg  <= mode_next;
            run_reg   <= run_next;
            minus_reg <= minus_next;
            cand_reg  <= cand_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/sts_tok_fifo.sv]
// Small token queue that takes up to two tokens and gives one per cycle when popped.
`default_nettype none

module sts_tok_fifo
    import sts_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [1:0] push_count,
    input  wire token_t     push_tok0,
    input  wire token_t     push_tok1,
    input  wire logic       pop,
    output token_t          head,
    output logic            not_empty,
    output logic            room_two
);

    token_t                 mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [FIFO_PTR_W-1:0]  wr_ptr_p1;

    assign wr_ptr_p1 = wr_ptr_reg + FIFO_PTR_W'(1);
    assign head      = mem[rd_ptr_reg];
    assign not_empty = (cnt_reg != '0);
    assign room_two  = (cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        cnt_next    = cnt_reg + FIFO_CNT_W'(push_count) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0) begin
            mem[wr_ptr_reg] <= push_tok0;
        end
        if (push_count == 2'd2) begin
            mem[wr_ptr_p1] <= push_tok1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    property p_count_in_range;
        @(posedge clk) disable iff (!rst_n)
        cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH);
    endproperty
    a_count_in_range: assert property (p_count_in_range)
        else $error("token queue count exceeds its depth");

endmodule

`default_nettype wire

[rtl/core/scheme_token_scanner_unit.sv]
// Top level of the streaming token scanner for a small Scheme-like language.
// The tokens that a character completes pass the input register and the token queue first.
// Throughput: one character per cycle while the queue has room for two tokens; a character
// ending a token and forming another gives two transfers, paced by the single output port.
// Reset (rst_n, asynchronous, active low) empties the input register and token queue and
// puts the scanner in its idle state between tokens with the keyword candidates all set.
`default_nettype none

module scheme_token_scanner_unit
    import sts_pkg::*;
#(
    parameter int MAX_TOKEN_LENGTH = MAX_TOKEN_LENGTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [4:0] token_kind, [12:5] token_length, zero pad
    output logic             m_axis_tlast    // last_of_run
);

    // Input register: holds one character until the queue has room for
    // the two tokens that it may cause.
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  ch_reg, ch_next;
    logic        in_take;
    logic        process;

    scan_out_t   res;
    token_t      head;
    logic        q_not_empty;
    logic        q_room_two;
    logic        pop;

    assign process       = in_valid_reg && q_room_two;
    assign s_axis_tready = !in_valid_reg || process;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        ch_next       = ch_reg;
        if (in_take) begin
            in_valid_next = 1'b1;
            ch_next       = s_axis_tdata;
        end else if (process) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg <= ch_next;
    end

    // The scanner decides, in one pass, which tokens the held character
    // completes, and its state advances only when the character is processed.
    sts_scan_core #(
        .MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (process),
        .ch    (ch_reg),
        .res   (res)
    );

    // The token queue separates the scanner from the output side, so a stalled consumer does not
    // stop the next character from being taken while the queue has room for two tokens.
    sts_tok_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (process ? res.count : 2'd0),
        .push_tok0  (res.tok0),
        .push_tok1  (res.tok1),
        .pop        (pop),
        .head       (head),
        .not_empty  (q_not_empty),
        .room_two   (q_room_two)
    );

    assign pop           = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = q_not_empty;
    assign m_axis_tdata  = {3'b000, head.length, head.kind};
    assign m_axis_tlast  = head.last;

    // An end of text token always reports zero length.
    property p_eof_zero_length;
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[4:0] == TK_EOF) |-> (m_axis_tdata[12:5] == 8'd0);
    endproperty
    a_eof_zero_length: assert property (p_eof_zero_length)
        else $error("end of text token with nonzero length");

    // A character waiting for queue room is neither lost nor changed.
    property p_input_held;
        @(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !process) |=> (in_valid_reg && $stable(ch_reg));
    endproperty
    a_input_held: assert property (p_input_held)
        else $error("held character was dropped or changed");

    // When a character causes two tokens, only the second closes the run.
    property p_pair_last_marks;
        @(posedge clk) disable iff (!rst_n)
        (process && res.count == 2'd2) |-> (!res.tok0.last && res.tok1.last);
    endproperty
    a_pair_last_marks: assert property (p_pair_last_marks)
        else $error("wrong last marks on a token pair");

    // A single token from a character always closes its run.
    property p_single_last_mark;
        @(posedge clk) disable iff (!rst_n)
        (process && res.count == 2'd1) |-> res.tok0.last;
    endproperty
    a_single_last_mark: assert property (p_single_last_mark)
        else $error("single token without last mark");

endmodule

`default_nettype wire
